// ----- design/ttad_pkg.sv -----
// Shared types, constants and helpers for the two-tier alarm debounce block.
// Used by every design module and by the port checker; no dependencies.
package ttad_pkg;

   localparam int CNT_W      = 8;   // debounce counter width
   localparam int LIM_W      = 8;   // width of the count limit registers
   localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_CO_LIMIT    = csr_index_type'(0);
   localparam csr_index_type CSR_TEMP_LIMIT  = csr_index_type'(1);
   localparam csr_index_type CSR_RISE_LIMIT  = csr_index_type'(2);
   localparam csr_index_type CSR_FALL_LIMIT  = csr_index_type'(3);
   localparam csr_index_type CSR_SMS_HOLDOFF = csr_index_type'(4);

   typedef logic [1:0] tier_type;

   localparam tier_type TIER_CLEAR = 2'd0;
   localparam tier_type TIER_WARN  = 2'd1;
   localparam tier_type TIER_ALARM = 2'd2;

   typedef logic [1:0] report_code_type;

   localparam report_code_type ALERT_NONE  = 2'd0;
   localparam report_code_type ALERT_TIER1 = 2'd1;
   localparam report_code_type ALERT_TIER2 = 2'd2;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [LIM_W-1:0] lim_type;

   typedef struct packed {
      logic [15:0]        co_limit;
      logic signed [13:0] temp_limit;
      lim_type            rise_count_limit;
      lim_type            fall_count_limit;
      logic [31:0]        sms_holdoff_ms;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        co_level;
      logic signed [13:0] temperature;
      logic               sensor_warm;
      logic               link_online;
      logic [31:0]        now_ms;
   } item_type;

   typedef struct packed {
      tier_type        alarm_tier;
      logic            yellow_lamp;
      logic            red_lamp;
      logic            buzzer_on;
      report_code_type alert_report;
      logic            sms_request;
   } result_type;

   // saturating increment
   function automatic cnt_type bump(cnt_type c);
      cnt_type r;
      r = (c == '1) ? c : c + cnt_type'(1);
      return r;
   endfunction

   function automatic logic reached(cnt_type c, lim_type lim);
      logic r;
      r = (CMP_W'(c) >= CMP_W'(lim));
      return r;
   endfunction

endpackage

// ----- design/ttad_csr.sv -----
// Configuration register file: limits, debounce counts and SMS holdoff.
// Depends on ttad_pkg.
module ttad_csr
   import ttad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CO_LIMIT:    cfg_in.co_limit         = csr_wr_data[15:0];
            CSR_TEMP_LIMIT:  cfg_in.temp_limit       = $signed(csr_wr_data[13:0]);
            CSR_RISE_LIMIT:  cfg_in.rise_count_limit = csr_wr_data[LIM_W-1:0];
            CSR_FALL_LIMIT:  cfg_in.fall_count_limit = csr_wr_data[LIM_W-1:0];
            CSR_SMS_HOLDOFF: cfg_in.sms_holdoff_ms   = csr_wr_data[31:0];
            default:         cfg_in = cfg_ff;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.co_limit         <= 16'd800;
         cfg_ff.temp_limit       <= 14'sd912;
         cfg_ff.rise_count_limit <= lim_type'(3);
         cfg_ff.fall_count_limit <= lim_type'(5);
         cfg_ff.sms_holdoff_ms   <= 32'd300000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/ttad_core.sv -----
// Classifier and alarm tier state: debounce counters, tier moves, SMS holdoff.
// Result is combinational from the staged item; state moves when update is high and the item is warm.
// Depends on ttad_pkg.
module ttad_core
   import ttad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   item,
   input  logic       update,
   output result_type result
);

   tier_type    tier_ff,     tier_in;
   cnt_type     rise_ff,     rise_in;
   cnt_type     fall_ff,     fall_in;
   logic [31:0] last_sms_ff, last_sms_in;
   logic        sms_sent_ff, sms_sent_in;

   logic    co_hi;
   logic    t_hi;
   logic    smp_t2;
   logic    smp_t1;
   logic    smp_safe;
   cnt_type rise_bump;
   cnt_type fall_bump;
   logic    enter2;
   logic    enter1;
   logic    sms_due;

   assign co_hi     = (item.co_level >= cfg.co_limit);
   assign t_hi      = ($signed(item.temperature) >= $signed(cfg.temp_limit));
   assign smp_t2    = co_hi & t_hi;
   assign smp_t1    = co_hi ^ t_hi;
   assign smp_safe  = ~co_hi & ~t_hi;
   assign rise_bump = bump(rise_ff);
   assign fall_bump = bump(fall_ff);
   assign sms_due   = ~sms_sent_ff | ((item.now_ms - last_sms_ff) >= cfg.sms_holdoff_ms);

   always_comb begin
      tier_in = tier_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      enter2  = 1'b0;
      enter1  = 1'b0;
      if (tier_ff == TIER_CLEAR) begin
         if (!smp_safe) begin
            rise_in = rise_bump;
            if (reached(rise_bump, cfg.rise_count_limit)) begin
               rise_in = '0;
               fall_in = '0;
               tier_in = smp_t2 ? TIER_ALARM : TIER_WARN;
               enter2  = smp_t2;
               enter1  = ~smp_t2;
            end
         end else begin
            rise_in = '0;
         end
      end else if (tier_ff == TIER_WARN) begin
         if (smp_t2) begin
            rise_in = rise_bump;
            if (reached(rise_bump, cfg.rise_count_limit)) begin
               tier_in = TIER_ALARM;
               rise_in = '0;
               fall_in = '0;
               enter2  = 1'b1;
            end
         end else if (smp_safe) begin
            fall_in = fall_bump;
            if (reached(fall_bump, cfg.fall_count_limit)) begin
               tier_in = TIER_CLEAR;
               rise_in = '0;
               fall_in = '0;
            end
         end else begin
            fall_in = '0;
         end
      end else begin
         // alarm; an impossible code 3 behaves the same
         if (!smp_t2) begin
            fall_in = fall_bump;
            if (reached(fall_bump, cfg.fall_count_limit)) begin
               tier_in = smp_safe ? TIER_CLEAR : TIER_WARN;
               rise_in = '0;
               fall_in = '0;
            end
         end else begin
            fall_in = '0;
         end
      end
   end

   always_comb begin
      last_sms_in = last_sms_ff;
      sms_sent_in = sms_sent_ff;
      if (enter2 && sms_due) begin
         last_sms_in = item.now_ms;
         sms_sent_in = 1'b1;
      end
   end

   always_comb begin
      if (!item.sensor_warm) begin
         result              = '0;
         result.alarm_tier   = tier_ff;
      end else begin
         result.alarm_tier   = tier_in;
         result.yellow_lamp  = (tier_in == TIER_WARN);
         result.red_lamp     = tier_in[1];
         result.buzzer_on    = tier_in[1];
         result.sms_request  = enter2 & sms_due;
         if (item.link_online && enter2) begin
            result.alert_report = ALERT_TIER2;
         end else if (item.link_online && enter1) begin
            result.alert_report = ALERT_TIER1;
         end else begin
            result.alert_report = ALERT_NONE;
         end
      end
   end

   // warm-up items leave all state untouched
   always_ff @(posedge clock) begin
      if (reset) begin
         tier_ff     <= TIER_CLEAR;
         rise_ff     <= '0;
         fall_ff     <= '0;
         last_sms_ff <= '0;
         sms_sent_ff <= 1'b0;
      end else if (update && item.sensor_warm) begin
         tier_ff     <= tier_in;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         last_sms_ff <= last_sms_in;
         sms_sent_ff <= sms_sent_in;
      end
   end

endmodule

// ----- design/two_tier_alarm_debounce_fsm_unit.sv -----
// Two-tier gas and temperature alarm with debounced tier changes.
// Depends on ttad_pkg, ttad_csr and ttad_core.
//
// Use:
//   req_* carries one reading per item; an item is taken on a clock edge with
//   req_valid high and req_stall low. Items with req_sample_valid low are
//   taken and dropped: they give no result and change nothing.
//   rsp_* carries one result per valid reading, held while rsp_stall is high.
//   csr_* writes the limits, debounce counts and SMS holdoff, one register a
//   cycle; the user writes only while no item is in flight (not enforced here).
// Timing:
//   An item waits in the input register, where the tier update and the
//   lamp/report/SMS decision are made; the result then goes into the result
//   register, which drives rsp_valid. One item per clock while rsp_stall is low.
// Stalls:
//   With the result register held by rsp_stall, one more item is taken into
//   the input register; after that req_stall goes high.
// Reset:
//   Synchronous, active high. Tier clear, counters zero, no SMS sent yet,
//   registers back to their defaults, both registers empty.
module two_tier_alarm_debounce_fsm_unit
   import ttad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_co_level,
   input  logic signed [13:0]    req_temperature,
   input  logic                  req_sample_valid,
   input  logic                  req_sensor_warm,
   input  logic                  req_link_online,
   input  logic [31:0]           req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tier_type              rsp_alarm_tier,
   output logic                  rsp_yellow_lamp,
   output logic                  rsp_red_lamp,
   output logic                  rsp_buzzer_on,
   output report_code_type       rsp_alert_report,
   output logic                  rsp_sms_request,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type    cfg;
   item_type   stg_item_ff;
   logic       stg_valid_ff, stg_valid_in;
   result_type out_res_ff;
   logic       out_valid_ff, out_valid_in;
   result_type core_res;
   logic       accept;
   logic       advance;
   logic       stg_load;

   ttad_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ttad_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (stg_item_ff),
      .update (advance),
      .result (core_res)
   );

   assign advance  = stg_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign stg_load = ~stg_valid_ff | advance;
   assign req_stall = ~stg_load;
   assign accept   = req_valid & stg_load;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (stg_load) begin
         stg_valid_in = accept & req_sample_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_item_ff.co_level    <= req_co_level;
         stg_item_ff.temperature <= req_temperature;
         stg_item_ff.sensor_warm <= req_sensor_warm;
         stg_item_ff.link_online <= req_link_online;
         stg_item_ff.now_ms      <= req_now_ms;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_alarm_tier   = out_res_ff.alarm_tier;
   assign rsp_yellow_lamp  = out_res_ff.yellow_lamp;
   assign rsp_red_lamp     = out_res_ff.red_lamp;
   assign rsp_buzzer_on    = out_res_ff.buzzer_on;
   assign rsp_alert_report = out_res_ff.alert_report;
   assign rsp_sms_request  = out_res_ff.sms_request;

endmodule

// ----- design/ttad_checker.sv -----
// Port-level checks on the result channel of the alarm unit, and the bind
// that attaches them. Depends on ttad_pkg and two_tier_alarm_debounce_fsm_unit.
module ttad_checker
   import ttad_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input tier_type        rsp_alarm_tier,
   input logic            rsp_yellow_lamp,
   input logic            rsp_red_lamp,
   input logic            rsp_buzzer_on,
   input report_code_type rsp_alert_report,
   input logic            rsp_sms_request
);

   // a held item keeps its tier, alert report and SMS request
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alarm_tier)
         && $stable(rsp_alert_report) && $stable(rsp_sms_request))
      else $error("result item changed while stalled");

   // warm-up blanks the lamps, so only a lit lamp pins the tier
   a_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alarm_tier <= TIER_ALARM
         && (!rsp_yellow_lamp || rsp_alarm_tier == TIER_WARN)
         && rsp_red_lamp == rsp_buzzer_on
         && (!rsp_red_lamp || rsp_alarm_tier == TIER_ALARM))
      else $error("lamp drive does not match tier");

   // a report names the tier just entered
   a_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alert_report != ALERT_NONE |-> rsp_alert_report == rsp_alarm_tier)
      else $error("alert report disagrees with tier");

   a_sms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sms_request |-> rsp_alarm_tier == TIER_ALARM && rsp_red_lamp)
      else $error("SMS request outside alarm tier");

endmodule

bind two_tier_alarm_debounce_fsm_unit ttad_checker u_ttad_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_alarm_tier   (rsp_alarm_tier),
   .rsp_yellow_lamp  (rsp_yellow_lamp),
   .rsp_red_lamp     (rsp_red_lamp),
   .rsp_buzzer_on    (rsp_buzzer_on),
   .rsp_alert_report (rsp_alert_report),
   .rsp_sms_request  (rsp_sms_request)
);
